// ===== rtl/fkc_pkg.sv =====
package fkc_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int KEY_W         = 24;
    localparam int CNT_W         = 8;

    localparam logic [CNT_W-1:0] CNT_MAX    = '1;
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
    localparam logic [CNT_W-1:0] THR_RESET  = CNT_W'(5);

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic   cmp_en;
        logic   alloc_en;
        logic   clear;
        t_key   key;
        t_count thr;
    } t_cell_ctrl;

    typedef struct packed {
        logic valid;
        logic match;
        logic win;
    } t_cell_stat;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

endpackage

// ===== rtl/fkc_in_if.sv =====
interface fkc_in_if;
    logic          valid;
    logic          ready;
    fkc_pkg::t_key key_code;
    logic          last_key;

    modport source (output valid, output key_code, output last_key, input ready);
    modport sink   (input valid, input key_code, input last_key, output ready);
endinterface

// ===== rtl/fkc_out_if.sv =====
interface fkc_out_if;
    logic          valid;
    logic          ready;
    logic          found;
    fkc_pkg::t_key winner_code;
    logic          table_overflow;

    modport source (output valid, output found, output winner_code,
                    output table_overflow, input ready);
    modport sink   (input valid, input found, input winner_code,
                    input table_overflow, output ready);
endinterface

// ===== rtl/fkc_cfg_if.sv =====
interface fkc_cfg_if;
    logic            valid;
    logic            ready;
    fkc_pkg::t_count count_threshold;

    modport source (output valid, output count_threshold, input ready);
    modport sink   (input valid, input count_threshold, output ready);
endinterface

// ===== rtl/fkc_cell.sv =====
module fkc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fkc_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_prev_valid,
    output fkc_pkg::t_cell_stat o_stat
);
    import fkc_pkg::*;

    logic   r_valid;
    t_key   r_key;
    t_count r_count;
    logic   r_match;
    logic   r_win;

    logic   hit;
    t_count inc;

    assign hit = r_valid && (r_key == i_ctrl.key);
    assign inc = (r_count == CNT_MAX) ? CNT_MAX : r_count + CNT_ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.alloc_en && !r_valid && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= hit;
            r_win   <= hit && (inc == i_ctrl.thr);
            if (hit) begin
                r_count <= inc;
            end
        end else if (i_ctrl.alloc_en && !r_valid && i_prev_valid) begin
            r_key   <= i_ctrl.key;
            r_count <= CNT_ONE;
        end
    end

    assign o_stat.valid = r_valid;
    assign o_stat.match = r_match;
    assign o_stat.win   = r_win;

endmodule

// ===== rtl/first_key_to_reach_count.sv =====
// first_key_to_reach_count
// A key beat passes through the compare and update states before reaching the result register.
// A new key beat is taken only in idle; a result stalled downstream holds the update state.
// Table lookup is a row of cells, each comparing its own entry in parallel.
// Reset (sync, active low): table empty, flags clear, threshold 5, no result pending.
module first_key_to_reach_count (
    input  logic i_clk,
    input  logic i_rst_n,
    fkc_in_if.sink    i_key_ch,
    fkc_cfg_if.sink   i_cfg_ch,
    fkc_out_if.source o_res_ch
);
    import fkc_pkg::*;

    t_state     r_state, n_state;
    t_key       r_key;
    logic       r_last;
    t_count     r_thr;
    logic       r_winner_seen;
    logic       r_ovf_seen;
    logic       r_out_valid;
    logic       r_found;
    t_key       r_code;
    logic       r_out_ovf;

    t_cell_ctrl ctrl;
    t_cell_stat stat [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_v, match_v, win_v;

    logic any_match, full, alloc, win_now, ovf_new, produce, out_free, commit;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            logic prev_valid;
            if (g == 0) begin : g_head
                assign prev_valid = 1'b1;
            end else begin : g_link
                assign prev_valid = stat[g-1].valid;
            end
            fkc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_prev_valid (prev_valid),
                .o_stat       (stat[g])
            );
            assign valid_v[g] = stat[g].valid;
            assign match_v[g] = stat[g].match;
            assign win_v[g]   = stat[g].win;
        end
    endgenerate

    assign any_match = |match_v;
    assign full      = valid_v[TABLE_ENTRIES-1];
    assign alloc     = !any_match && !full;
    assign win_now   = !r_winner_seen && ((|win_v) || (alloc && (r_thr == CNT_ONE)));
    assign ovf_new   = r_ovf_seen || (!r_winner_seen && !any_match && full);
    assign produce   = win_now || (r_last && !r_winner_seen);
    assign out_free  = !r_out_valid || o_res_ch.ready;
    assign commit    = (r_state == S_UPD) && (!produce || out_free);

    always_comb begin
        ctrl.cmp_en   = (r_state == S_CMP) && !r_winner_seen;
        ctrl.alloc_en = commit && !r_winner_seen && alloc;
        ctrl.clear    = commit && r_last;
        ctrl.key      = r_key;
        ctrl.thr      = r_thr;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_key_ch.valid) n_state = S_CMP;
            end
            S_CMP: n_state = S_UPD;
            S_UPD: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_key_ch.ready = (r_state == S_IDLE);
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_thr         <= THR_RESET;
            r_winner_seen <= 1'b0;
            r_ovf_seen    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_ch.valid) begin
                r_thr <= i_cfg_ch.count_threshold;
            end
            if (commit) begin
                r_winner_seen <= r_last ? 1'b0 : (r_winner_seen || win_now);
                r_ovf_seen    <= r_last ? 1'b0 : ovf_new;
            end
            if (commit && produce) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key_ch.valid && i_key_ch.ready) begin
            r_key  <= i_key_ch.key_code;
            r_last <= i_key_ch.last_key;
        end
        if (commit && produce) begin
            r_found   <= win_now;
            r_code    <= win_now ? r_key : '0;
            r_out_ovf <= ovf_new;
        end
    end

    assign o_res_ch.valid          = r_out_valid;
    assign o_res_ch.found          = r_found;
    assign o_res_ch.winner_code    = r_code;
    assign o_res_ch.table_overflow = r_out_ovf;

endmodule
